// ----- rtl/hmu_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hmu_pkg
// Shared constants for the hypotenuse magnitude unit.
// ============================================================================
package hmu_pkg;

    localparam int DATA_WIDTH_DEF = 16;

endpackage

// ----- rtl/hypot_magnitude_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hypot_magnitude_unit
// Elementwise magnitude: floor(sqrt(a_re^2 + b_re^2 [+ a_im^2 + b_im^2])).
// ----------------------------------------------------------------------------
// Input channel: i_valid with payload i_func, i_a_re, i_a_im, i_b_re, i_b_im;
// a transfer happens on a rising edge with i_valid high and o_stall low.
// i_func = 0 uses the real parts only, i_func = 1 adds the imaginary parts.
// Output channel: o_valid with o_magnitude; a transfer happens on a rising
// edge with o_valid high and i_stall low.
// Each item passes through the magnitude, square and adder-tree registers,
// then through the root stages, each of which adds a root bit.
// One item per cycle while o_stall is low; every stage holds a valid bit.
// The whole pipeline advances together. o_stall rises only while a result
// sits in the output register and i_stall is high; then every stage holds,
// nothing is lost or repeated, and the result stays on the output.
// Reset (i_rst_n low, synchronous) clears all valid bits; the pipeline is
// empty after it and takes a new item on the next cycle.
// ============================================================================
module hypot_magnitude_unit #(
    parameter int DATA_WIDTH = hmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [DATA_WIDTH:0]          o_magnitude
);

    localparam int SW = 2 * DATA_WIDTH + 2;
    localparam int RW = DATA_WIDTH + 4;
    localparam int NW = DATA_WIDTH + 1;

    logic          w_en;
    logic          w_vld  [NW+1];
    logic [SW-1:0] w_rad  [NW+1];
    logic [RW-1:0] w_rem  [NW+1];
    logic [NW-1:0] w_root [NW+1];

    assign w_en    = !(w_vld[NW] && i_stall);
    assign o_stall = !w_en;

    hmu_square #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_func  (i_func),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_vld   (w_vld[0]),
        .o_sum   (w_rad[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < NW; g++) begin : g_root
        hmu_sqrt_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_vld   (w_vld[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    assign o_valid     = w_vld[NW];
    assign o_magnitude = w_root[NW];

endmodule

// ----- rtl/hmu_square.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hmu_square
// Front end: operand magnitudes, squares and sum of squares, four stages.
// ============================================================================
module hmu_square #(
    parameter int DATA_WIDTH = hmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic                      i_func,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                      o_vld,
    output logic [2*DATA_WIDTH+1:0]   o_sum
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 2;

    logic [W-1:0]  n_mag  [4];
    logic [W-1:0]  r_mag  [4];
    logic [PW-1:0] r_sq   [4];
    logic [PW:0]   r_pair [2];
    logic [SW-1:0] r_sum;
    logic [3:0]    r_vld;
    logic [W-1:0]  w_opd  [4];

    assign w_opd[0] = i_a_re;
    assign w_opd[1] = i_b_re;
    assign w_opd[2] = i_func ? i_a_im : '0;
    assign w_opd[3] = i_func ? i_b_im : '0;

    // most negative value negates to itself, which reads right as unsigned
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_mag[k] = w_opd[k][W-1] ? (~w_opd[k] + W'(1)) : w_opd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_mag[k] <= n_mag[k];
                r_sq[k]  <= PW'(r_mag[k]) * PW'(r_mag[k]);
            end
            r_pair[0] <= (PW+1)'(r_sq[0]) + (PW+1)'(r_sq[1]);
            r_pair[1] <= (PW+1)'(r_sq[2]) + (PW+1)'(r_sq[3]);
            r_sum     <= SW'(r_pair[0]) + SW'(r_pair[1]);
        end
    end

    assign o_vld = r_vld[3];
    assign o_sum = r_sum;

endmodule

// ----- rtl/hmu_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hmu_sqrt_stage
// One restoring square-root step: one root bit per stage, registered.
// ============================================================================
module hmu_sqrt_stage #(
    parameter int DATA_WIDTH = hmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [2*DATA_WIDTH+1:0]   i_rad,
    input  logic [DATA_WIDTH+3:0]     i_rem,
    input  logic [DATA_WIDTH:0]       i_root,
    output logic                      o_vld,
    output logic [2*DATA_WIDTH+1:0]   o_rad,
    output logic [DATA_WIDTH+3:0]     o_rem,
    output logic [DATA_WIDTH:0]       o_root
);

    localparam int SW = 2 * DATA_WIDTH + 2;
    localparam int RW = DATA_WIDTH + 4;
    localparam int NW = DATA_WIDTH + 1;

    logic [RW-1:0] w_rem_sh;
    logic [RW-1:0] w_trial;
    logic          w_ge;
    logic [RW-1:0] n_rem;
    logic [NW-1:0] n_root;

    logic          r_vld;
    logic [SW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_root;

    assign w_rem_sh = {i_rem[RW-3:0], i_rad[SW-1:SW-2]};
    assign w_trial  = {1'b0, i_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign n_rem    = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
    assign n_root   = {i_root[NW-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[SW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
